/* hw/rtl/ditp_pkg.sv */
// Shared types, codes and helper functions of the disk image track parser.
package ditp_pkg;

  localparam int MAX_SECTORS = 256;
  localparam int SLOT_W      = $clog2(MAX_SECTORS);

  localparam logic [7:0] SIZE_PER_SECTOR = 8'hFF;
  localparam logic [7:0] HEAD_MASK       = 8'h3F;
  localparam logic [7:0] FILL_DEFAULT    = 8'hF6;
  localparam logic [7:0] GAP_SHORT       = 8'h50;
  localparam logic [7:0] GAP_NINE        = 8'h52;
  localparam logic [7:0] GAP_LONG        = 8'h17;
  localparam logic [7:0] STATUS_MAX      = 8'd8;
  localparam int         BASE_LEN        = 128;

  localparam logic [7:0] END_CLEAN      = 8'd0;
  localparam logic [7:0] END_TRUNCATED  = 8'd1;
  localparam logic [7:0] END_BAD_STATUS = 8'd2;

  typedef enum logic [2:0] {
    KIND_TRACK  = 3'd0,
    KIND_SECTOR = 3'd1,
    KIND_DATA   = 3'd2,
    KIND_LAST   = 3'd3,
    KIND_END    = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    PH_HDR_MODE  = 4'd0,
    PH_HDR_CYL   = 4'd1,
    PH_HDR_HEAD  = 4'd2,
    PH_HDR_COUNT = 4'd3,
    PH_HDR_SIZE  = 4'd4,
    PH_IDS       = 4'd5,
    PH_CMAP      = 4'd6,
    PH_HMAP      = 4'd7,
    PH_LENLO     = 4'd8,
    PH_LENHI     = 4'd9,
    PH_STATUS    = 4'd10,
    PH_FILL      = 4'd11,
    PH_DATA      = 4'd12
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } item_t;

  typedef struct packed {
    kind_t       out_kind;
    logic [7:0]  cylinder;
    logic [7:0]  head;
    logic [7:0]  sector_id;
    logic [7:0]  size_code;
    logic [15:0] sector_length;
    logic [2:0]  status_marks;
    logic [7:0]  filler;
    logic        stored_copies;
    logic [1:0]  data_rate;
    logic [1:0]  rec_mode;
    logic [7:0]  value;
  } desc_t;

  // Write side of the per-sector tables
  typedef struct packed {
    logic              id_we;
    logic              cyl_we;
    logic              head_we;
    logic              len_we;
    logic [SLOT_W-1:0] addr;
    logic [7:0]        byte_data;
    logic [15:0]       len_data;
  } store_wr_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  cyl;
    logic [7:0]  head;
    logic [15:0] len;
  } store_rd_t;

  function automatic logic [15:0] track_len(logic [7:0] code);
    logic [31:0] full;
    full = 32'(BASE_LEN) << code[3:0];
    if (code == SIZE_PER_SECTOR) return 16'hFFFF;
    if (code >= 8'd16) return 16'h0000;
    return full[15:0];
  endfunction

  // Number of halvings that bring len down to BASE_LEN or less:
  // floor(len >> s) <= 128 holds once len < 129 << s.
  function automatic logic [7:0] shift_of(logic [15:0] len);
    logic [3:0] s;
    s = '0;
    for (int i = 0; i < 9; i++) begin
      if (32'(len) >= (32'(BASE_LEN + 1) << i)) s = s + 4'd1;
    end
    return {4'b0000, s};
  endfunction

  function automatic logic [1:0] rate_of_mode(logic [7:0] mode);
    logic [1:0] r;
    unique case (mode)
      8'd0, 8'd3:                 r = 2'd2;
      8'd1, 8'd2, 8'd4, 8'd5:     r = 2'd1;
      8'd6, 8'd9:                 r = 2'd3;
      default:                    r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] rec_of_mode(logic [7:0] mode);
    logic [1:0] r;
    unique case (mode)
      8'd0, 8'd1, 8'd2, 8'd6:     r = 2'd1;
      8'd3, 8'd4, 8'd5, 8'd9:     r = 2'd2;
      default:                    r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] marks_of(logic [3:0] st);
    logic [2:0] m;
    unique case (st)
      4'd0:       m = 3'd1;
      4'd3, 4'd4: m = 3'd4;
      4'd5, 4'd6: m = 3'd2;
      4'd7, 4'd8: m = 3'd6;
      default:    m = 3'd0;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] gap_of(logic [7:0] count);
    if (count < 8'd9) return GAP_SHORT;
    if (count < 8'd10) return GAP_NINE;
    return GAP_LONG;
  endfunction

endpackage

/* hw/rtl/disk_image_track_parser_unit.sv */
// Top level of the disk image track parser: byte parser, sector tables and output skid.
//
// Takes one byte of the track record stream per cycle while item_ready is
// high and turns it into track descriptors, sector descriptors and data
// bytes, whatever the phase of the byte: the sector id, cylinder, head and
// length tables live in single-port-write memories whose registered read port
// is always pointed at the next sector slot, so the entry a status byte needs
// is ready when that byte arrives, with a write to the same slot forwarded
// straight to the read register. Results go through an output register backed
// by a one-entry skid buffer; item_ready drops only while that skid entry is
// full, so a stall on desc holds off the input once a result has been parked,
// for as long as the stall lasts. After an end of input inside a track or an
// unknown status byte the parser reports an end transaction and then swallows
// every further byte until reset. There is no clearing pass after reset.
module disk_image_track_parser_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  ditp_pkg::item_t item,
  output logic            desc_valid,
  input  logic            desc_ready,
  output ditp_pkg::desc_t desc
);
  import ditp_pkg::*;

  // Parser state
  phase_t      phase, phase_next;
  logic [7:0]  track_mode, track_mode_next;
  logic [7:0]  track_cylinder, track_cylinder_next;
  logic [7:0]  head_and_flags, head_and_flags_next;
  logic [7:0]  sector_count, sector_count_next;
  logic [7:0]  track_size_code, track_size_code_next;
  logic [7:0]  sector_index, sector_index_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [7:0]  length_low_hold, length_low_hold_next;
  logic [3:0]  pending_status, pending_status_next;
  logic        error_latched, error_latched_next;

  // Result of the current transaction, before the output register
  logic  res_valid;
  desc_t res;

  // Output skid
  logic  skid_valid;
  desc_t skid;

  store_wr_t wr;
  store_rd_t rd;

  logic       acc;
  logic [7:0] b;
  logic [7:0] idx_inc;
  logic [15:0] sec_len;

  assign acc        = item_valid && item_ready;
  assign b          = item.data_byte;
  assign idx_inc    = sector_index + 8'd1;
  assign item_ready = !skid_valid;

  // Length of the sector in the current slot
  assign sec_len = (track_size_code == SIZE_PER_SECTOR) ? rd.len : track_len(track_size_code);

  ditp_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (sector_index_next[SLOT_W-1:0]),
    .rd      (rd)
  );

  // Next table or status phase after finishing a table
  function automatic phase_t phase_after(phase_t ph, logic [7:0] flags, logic [7:0] code);
    if (ph < PH_CMAP && flags[7]) return PH_CMAP;
    if (ph < PH_HMAP && flags[6]) return PH_HMAP;
    if (ph < PH_LENLO && code == SIZE_PER_SECTOR) return PH_LENLO;
    return PH_STATUS;
  endfunction

  function automatic desc_t sector_desc(logic [3:0] st, logic [7:0] fill, logic raw);
    desc_t d;
    d               = '0;
    d.out_kind      = KIND_SECTOR;
    d.cylinder      = head_and_flags[7] ? rd.cyl : track_cylinder;
    d.head          = head_and_flags[6] ? rd.head : (head_and_flags & HEAD_MASK);
    d.sector_id     = rd.id;
    d.size_code     = (track_size_code == SIZE_PER_SECTOR) ? shift_of(sec_len)
                                                           : track_size_code;
    d.sector_length = sec_len;
    d.status_marks  = marks_of(st);
    d.filler        = fill;
    d.stored_copies = raw;
    return d;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HDR_MODE;
      track_mode      <= '0;
      track_cylinder  <= '0;
      head_and_flags  <= '0;
      sector_count    <= '0;
      track_size_code <= '0;
      sector_index    <= '0;
      bytes_left      <= '0;
      length_low_hold <= '0;
      pending_status  <= '0;
      error_latched   <= 1'b0;
    end else begin
      phase           <= phase_next;
      track_mode      <= track_mode_next;
      track_cylinder  <= track_cylinder_next;
      head_and_flags  <= head_and_flags_next;
      sector_count    <= sector_count_next;
      track_size_code <= track_size_code_next;
      sector_index    <= sector_index_next;
      bytes_left      <= bytes_left_next;
      length_low_hold <= length_low_hold_next;
      pending_status  <= pending_status_next;
      error_latched   <= error_latched_next;
    end
  end

  always_comb begin
    phase_next           = phase;
    track_mode_next      = track_mode;
    track_cylinder_next  = track_cylinder;
    head_and_flags_next  = head_and_flags;
    sector_count_next    = sector_count;
    track_size_code_next = track_size_code;
    sector_index_next    = sector_index;
    bytes_left_next      = bytes_left;
    length_low_hold_next = length_low_hold;
    pending_status_next  = pending_status;
    error_latched_next   = error_latched;
    res_valid            = 1'b0;
    res                  = '0;
    wr                   = '0;
    wr.addr              = sector_index[SLOT_W-1:0];
    wr.byte_data         = b;
    wr.len_data          = {b, length_low_hold};

    if (acc && !error_latched) begin
      if (item.end_of_input) begin
        // End inside a header is clean; inside a track it is truncation
        res_valid    = 1'b1;
        res.out_kind = KIND_END;
        if (phase <= PH_HDR_SIZE) begin
          phase_next = PH_HDR_MODE;
          res.value  = END_CLEAN;
        end else begin
          error_latched_next = 1'b1;
          res.value          = END_TRUNCATED;
        end
      end else begin
        unique case (phase)
          PH_HDR_MODE: begin
            track_mode_next = b;
            phase_next      = PH_HDR_CYL;
          end
          PH_HDR_CYL: begin
            track_cylinder_next = b;
            phase_next          = PH_HDR_HEAD;
          end
          PH_HDR_HEAD: begin
            head_and_flags_next = b;
            phase_next          = PH_HDR_COUNT;
          end
          PH_HDR_COUNT: begin
            sector_count_next = b;
            phase_next        = PH_HDR_SIZE;
          end
          PH_HDR_SIZE: begin
            track_size_code_next = b;
            sector_index_next    = '0;
            res_valid            = 1'b1;
            res.out_kind         = KIND_TRACK;
            res.cylinder         = track_cylinder;
            res.head             = head_and_flags & HEAD_MASK;
            res.sector_id        = sector_count;
            res.size_code        = b;
            res.sector_length    = track_len(b);
            res.data_rate        = rate_of_mode(track_mode);
            res.rec_mode         = rec_of_mode(track_mode);
            res.value            = gap_of(sector_count);
            phase_next           = (sector_count == 8'd0) ? PH_HDR_MODE : PH_IDS;
          end
          PH_IDS, PH_CMAP, PH_HMAP: begin
            wr.id_we   = (phase == PH_IDS);
            wr.cyl_we  = (phase == PH_CMAP);
            wr.head_we = (phase == PH_HMAP);
            if (idx_inc == sector_count) begin
              sector_index_next = '0;
              phase_next        = phase_after(phase, head_and_flags, track_size_code);
            end else begin
              sector_index_next = idx_inc;
            end
          end
          PH_LENLO: begin
            length_low_hold_next = b;
            phase_next           = PH_LENHI;
          end
          PH_LENHI: begin
            wr.len_we = 1'b1;
            if (idx_inc == sector_count) begin
              sector_index_next = '0;
              phase_next        = phase_after(PH_LENLO, head_and_flags, track_size_code);
            end else begin
              sector_index_next = idx_inc;
              phase_next        = PH_LENLO;
            end
          end
          PH_STATUS: begin
            if (b > STATUS_MAX) begin
              res_valid          = 1'b1;
              res.out_kind       = KIND_END;
              res.value          = END_BAD_STATUS;
              error_latched_next = 1'b1;
            end else begin
              pending_status_next = b[3:0];
              if (b == 8'd0) begin
                res_valid         = 1'b1;
                res               = sector_desc(b[3:0], FILL_DEFAULT, 1'b0);
                sector_index_next = idx_inc;
                phase_next        = (idx_inc == sector_count) ? PH_HDR_MODE : PH_STATUS;
              end else if (!b[0]) begin
                // Compressed sector: wait for the fill byte
                phase_next = PH_FILL;
              end else begin
                res_valid       = 1'b1;
                res             = sector_desc(b[3:0], FILL_DEFAULT, 1'b1);
                bytes_left_next = sec_len;
                if (sec_len == 16'd0) begin
                  sector_index_next = idx_inc;
                  phase_next = (idx_inc == sector_count) ? PH_HDR_MODE : PH_STATUS;
                end else begin
                  phase_next = PH_DATA;
                end
              end
            end
          end
          PH_FILL: begin
            res_valid         = 1'b1;
            res               = sector_desc(pending_status, b, 1'b0);
            sector_index_next = idx_inc;
            phase_next        = (idx_inc == sector_count) ? PH_HDR_MODE : PH_STATUS;
          end
          PH_DATA: begin
            bytes_left_next = bytes_left - 16'd1;
            res_valid       = 1'b1;
            res.value       = b;
            if (bytes_left == 16'd1) begin
              res.out_kind      = KIND_LAST;
              sector_index_next = idx_inc;
              phase_next = (idx_inc == sector_count) ? PH_HDR_MODE : PH_STATUS;
            end else begin
              res.out_kind = KIND_DATA;
            end
          end
          default: begin
            phase_next = PH_HDR_MODE;
          end
        endcase
      end
    end
  end

  // Output register with skid: park a result in the skid while desc is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      desc_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!desc_valid || desc_ready) begin
      if (skid_valid) begin
        desc_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        desc_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!desc_valid || desc_ready) begin
      desc <= skid_valid ? skid : res;
    end else if (res_valid) begin
      skid <= res;
    end
  end

  // The skid only fills behind a held output register
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> desc_valid)
    else $error("skid holds a transaction while the output register is empty");

  // Once latched, an error silences the parser
  assert property (@(posedge clk) disable iff (rst) error_latched |-> !res_valid)
    else $error("result produced after an error was latched");

  // Sector phases always point at a slot inside the track
  assert property (@(posedge clk) disable iff (rst)
    (phase >= PH_IDS && phase <= PH_DATA) |-> (sector_index < sector_count))
    else $error("sector index ran past the sector count");

  // A data phase always has bytes left to deliver
  assert property (@(posedge clk) disable iff (rst) (phase == PH_DATA) |-> (bytes_left != 16'd0))
    else $error("data phase entered with no bytes left");

  // An error latches only on an end transaction
  assert property (@(posedge clk) disable iff (rst)
    $rose(error_latched) |-> $past(res_valid && (res.out_kind == KIND_END)))
    else $error("error latched without an end transaction");

endmodule

/* hw/rtl/ditp_store.sv */
// Per-sector tables: id, cylinder, head and length memories with write forwarding.
module ditp_store (
  input  logic                            clk,
  input  ditp_pkg::store_wr_t             wr,
  input  logic [ditp_pkg::SLOT_W-1:0]     rd_addr,
  output ditp_pkg::store_rd_t             rd
);
  import ditp_pkg::*;

  logic [7:0]  id_mem   [MAX_SECTORS];
  logic [7:0]  cyl_mem  [MAX_SECTORS];
  logic [7:0]  head_mem [MAX_SECTORS];
  logic [15:0] len_mem  [MAX_SECTORS];

  logic hit;
  assign hit = (wr.addr == rd_addr);

  always_ff @(posedge clk) begin
    if (wr.id_we)   id_mem[wr.addr]   <= wr.byte_data;
    if (wr.cyl_we)  cyl_mem[wr.addr]  <= wr.byte_data;
    if (wr.head_we) head_mem[wr.addr] <= wr.byte_data;
    if (wr.len_we)  len_mem[wr.addr]  <= wr.len_data;
  end

  // Registered read; a same-edge write to the read address wins
  always_ff @(posedge clk) begin
    rd.id   <= (wr.id_we && hit)   ? wr.byte_data : id_mem[rd_addr];
    rd.cyl  <= (wr.cyl_we && hit)  ? wr.byte_data : cyl_mem[rd_addr];
    rd.head <= (wr.head_we && hit) ? wr.byte_data : head_mem[rd_addr];
    rd.len  <= (wr.len_we && hit)  ? wr.len_data  : len_mem[rd_addr];
  end

endmodule
